### sv/pngu_pkg.sv
// pngu_pkg: shared widths, codes, types and the paeth predictor function
// for the png scanline unfilter block
// no dependencies
package pngu_pkg;

  localparam int unsigned RAW_W       = 8;
  localparam int unsigned BPP_W       = 3;
  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned ROWS_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // filter codes as they arrive in the row's first byte, plus a marker for bad codes
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } pngu_filter_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP        = 2'd0,
    CFG_ROW_BYTES  = 2'd1,
    CFG_IMAGE_ROWS = 2'd2
  } pngu_cfg_idx_e;

  // neighbours of the current byte
  typedef struct packed {
    logic [RAW_W-1:0] left;
    logic [RAW_W-1:0] up;
    logic [RAW_W-1:0] upleft;
  } pngu_nbr_t;

  // paeth predictor, ties go left, then up, then upper-left
  function automatic logic [RAW_W-1:0] paeth(input logic [RAW_W-1:0] a,
                                             input logic [RAW_W-1:0] b,
                                             input logic [RAW_W-1:0] c);
    logic [RAW_W+1:0] sum_ab;
    logic [RAW_W+1:0] sum_cc;
    logic [RAW_W+1:0] pa;
    logic [RAW_W+1:0] pb;
    logic [RAW_W+1:0] pc;
    sum_ab = {2'b00, a} + {2'b00, b};
    sum_cc = {2'b00, c} + {2'b00, c};
    pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
    pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
    pc = (sum_ab > sum_cc) ? (sum_ab - sum_cc) : (sum_cc - sum_ab);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

### sv/pngu_in_if.sv
// pngu_in_if: input byte channel, valid/ready with one raw byte per item
// depends on pngu_pkg
interface pngu_in_if import pngu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

### sv/pngu_out_if.sv
// pngu_out_if: result channel, valid/ready with the rebuilt byte and row flags
// depends on pngu_pkg
interface pngu_out_if import pngu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] pixel_byte;
  logic             row_end;
  logic             image_end;
  logic             bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink (input valid, input pixel_byte, input row_end, input image_end,
                input bad_filter, output ready);
endinterface

### sv/pngu_cfg_if.sv
// pngu_cfg_if: configuration write channel, valid/ready with register index and data
// depends on pngu_pkg
interface pngu_cfg_if import pngu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/pngu_line_store.sv
// pngu_line_store: previous-row byte memory, one write and one registered read port
// depends on pngu_pkg
module pngu_line_store import pngu_pkg::*; #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [RAW_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [RAW_W-1:0] rd_data_o
);

  logic [RAW_W-1:0] mem_q [DEPTH];
  logic [RAW_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/pngu_predict.sv
// pngu_predict: filter predictor and modulo-256 add for one byte
// depends on pngu_pkg (filter codes, neighbour struct, paeth function)
module pngu_predict import pngu_pkg::*; (
  input  pngu_filter_e     filter_i,
  input  pngu_nbr_t        nbr_i,
  input  logic [RAW_W-1:0] raw_i,
  output logic [RAW_W-1:0] val_o
);

  logic [RAW_W:0]   avg_sum;
  logic [RAW_W-1:0] pred;

  assign avg_sum = {1'b0, nbr_i.left} + {1'b0, nbr_i.up};

  // select prediction
  always_comb begin
    case (filter_i)
      FILT_SUB:   pred = nbr_i.left;
      FILT_UP:    pred = nbr_i.up;
      FILT_AVG:   pred = avg_sum[RAW_W:1];
      FILT_PAETH: pred = paeth(nbr_i.left, nbr_i.up, nbr_i.upleft);
      default:    pred = '0;
    endcase
  end

  // sum wraps at 256
  assign val_o = pred + raw_i;

endmodule

### sv/png_scanline_unfilter.sv
// png_scanline_unfilter: top level, input register, reconstruction, result register.
// A byte accepted into the input register is rebuilt into the result register when it
// moves on and is shown on the result channel until taken. Throughput: one byte per
// cycle unless the result channel stalls, set by the left-neighbour loop through the
// history registers and the one-byte-ahead read of the line store.
// Reset: control, counters and history cleared, config set to its defaults; the line store is not cleared.
module png_scanline_unfilter import pngu_pkg::*; #(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  pngu_in_if.sink    in_chan,
  pngu_out_if.source out_chan,
  pngu_cfg_if.sink   cfg_chan
);

  localparam int unsigned AW  = $clog2(MAX_ROW_BYTES);
  localparam int unsigned CW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // configuration registers, stored already clamped
  logic [PIW-1:0]    bpp_m1_q;
  logic [CW-1:0]     rb_q;
  logic [ROWS_W-1:0] rows_q;
  logic [3:0]        bpp_w;
  logic [CW-1:0]     rb_w;
  logic [ROWS_W-1:0] rows_w;
  logic              cfg_acc;

  // input register
  logic             in_valid_q;
  logic             in_valid_d;
  logic [RAW_W-1:0] in_byte_q;
  logic             in_acc;
  logic             adv;

  // row state
  logic [CW-1:0]     col_q;
  logic [ROWS_W-1:0] row_q;
  pngu_filter_e      filt_q;
  logic [RAW_W-1:0]  lh_q  [MAX_PIXEL_BYTES];
  logic [RAW_W-1:0]  ulh_q [MAX_PIXEL_BYTES];

  // datapath
  logic             is_filt;
  logic             left_ok;
  logic             has_up;
  logic [AW-1:0]    x;
  logic [RAW_W-1:0] up_rd;
  pngu_nbr_t        nbr;
  logic [RAW_W-1:0] val;
  logic             rend;
  logic             iend;
  pngu_filter_e     filt_code;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // result register
  logic             out_valid_q;
  logic             out_valid_d;
  logic [RAW_W-1:0] out_byte_q;
  logic             out_rend_q;
  logic             out_iend_q;
  logic             out_bad_q;

  // config writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid;

  // clamp incoming config values
  always_comb begin
    bpp_w = {1'b0, cfg_chan.data[BPP_W-1:0]};
    if (bpp_w == 4'd0) begin
      bpp_w = 4'd1;
    end else if (bpp_w > 4'(MAX_PIXEL_BYTES)) begin
      bpp_w = 4'(MAX_PIXEL_BYTES);
    end
    if (cfg_chan.data[ROW_BYTES_W-1:0] == '0) begin
      rb_w = CW'(1);
    end else if (32'(cfg_chan.data[ROW_BYTES_W-1:0]) > 32'(MAX_ROW_BYTES)) begin
      rb_w = CW'(MAX_ROW_BYTES);
    end else begin
      rb_w = CW'(cfg_chan.data[ROW_BYTES_W-1:0]);
    end
    rows_w = (cfg_chan.data[ROWS_W-1:0] == '0) ? ROWS_W'(1) : cfg_chan.data[ROWS_W-1:0];
  end

  // config register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_m1_q <= '0;
      rb_q     <= CW'(1);
      rows_q   <= ROWS_W'(1);
    end else if (cfg_acc) begin
      case (pngu_cfg_idx_e'(cfg_chan.index))
        CFG_BPP:        bpp_m1_q <= PIW'(bpp_w - 4'd1);
        CFG_ROW_BYTES:  rb_q     <= rb_w;
        CFG_IMAGE_ROWS: rows_q   <= rows_w;
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register can take it or it holds a filter byte
  assign is_filt       = (col_q == '0);
  assign adv           = in_valid_q && (is_filt || !out_valid_q || out_chan.ready);
  assign in_chan.ready = !in_valid_q || adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_chan.raw_byte;
    end
  end

  // neighbour selection
  assign x          = AW'(col_q - CW'(1));
  assign has_up     = (row_q != '0);
  assign left_ok    = 32'(col_q) > (32'(bpp_m1_q) + 32'd1);
  assign nbr.up     = has_up ? up_rd : '0;
  assign nbr.left   = left_ok ? lh_q[bpp_m1_q] : '0;
  assign nbr.upleft = (has_up && left_ok) ? ulh_q[bpp_m1_q] : '0;

  pngu_predict u_predict (
    .filter_i (filt_q),
    .nbr_i    (nbr),
    .raw_i    (in_byte_q),
    .val_o    (val)
  );

  // row and image end
  assign rend = (col_q >= rb_q);
  assign iend = rend && ((17'(row_q) + 17'd1) >= 17'(rows_q));

  assign filt_code = (in_byte_q <= RAW_W'(FILT_PAETH)) ? pngu_filter_e'(in_byte_q[2:0])
                                                       : FILT_BAD;

  // fetch the upper byte for the next data byte one step ahead
  assign rd_en   = adv && (is_filt || !rend);
  assign rd_addr = is_filt ? '0 : x + AW'(1);

  pngu_line_store #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (adv && !is_filt),
    .wr_addr_i (x),
    .wr_data_i (val),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (up_rd)
  );

  // counters and filter code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      filt_q <= FILT_NONE;
    end else if (adv) begin
      if (is_filt) begin
        filt_q <= filt_code;
        col_q  <= CW'(1);
      end else if (rend) begin
        col_q <= '0;
        row_q <= iend ? '0 : row_q + ROWS_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // left and upper-left history, cleared at each row start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        lh_q[i]  <= '0;
        ulh_q[i] <= '0;
      end
    end else if (adv) begin
      if (is_filt) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          lh_q[i]  <= '0;
          ulh_q[i] <= '0;
        end
      end else begin
        for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
          lh_q[i]  <= lh_q[i-1];
          ulh_q[i] <= ulh_q[i-1];
        end
        lh_q[0]  <= val;
        ulh_q[0] <= nbr.up;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && !is_filt) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !is_filt) begin
      out_byte_q <= val;
      out_rend_q <= rend;
      out_iend_q <= iend;
      out_bad_q  <= (filt_q == FILT_BAD);
    end
  end

  assign out_chan.valid      = out_valid_q;
  assign out_chan.pixel_byte = out_byte_q;
  assign out_chan.row_end    = out_rend_q;
  assign out_chan.image_end  = out_iend_q;
  assign out_chan.bad_filter = out_bad_q;

  // a filter byte always opens the row at the first data column
  a_filter_opens_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_filt) |=> (col_q == CW'(1)))
    else $error("column not at first data byte after filter byte");

  // a row end sends the block back to waiting for a filter byte
  a_row_end_clears_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_filt && rend) |=> (col_q == '0))
    else $error("column not cleared after row end");

  // image end restarts the row count
  a_image_end_clears_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_filt && iend) |=> (row_q == '0))
    else $error("row count not cleared after image end");

  // every data byte that moves on shows up as a result
  a_data_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_filt) |=> (out_valid_q && out_byte_q == $past(val)))
    else $error("data byte did not reach the result register");

  // an image end result is always also a row end
  a_image_end_is_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_iend_q) |-> out_rend_q)
    else $error("image end without row end");

endmodule
